// File: src/nal_length_prefix_to_start_code_defines.svh
// ----------------------------------------------------------------------------
// Length-prefix to start-code converter: assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef NAL_LENGTH_PREFIX_TO_START_CODE_DEFINES_SVH
`define NAL_LENGTH_PREFIX_TO_START_CODE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NL2SC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nl2sc assertion failed");

// next-cycle implication, disabled in reset
`define NL2SC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nl2sc assertion failed");

`endif

// File: src/nl2sc_pkg.sv
// ----------------------------------------------------------------------------
// nl2sc_pkg
// Command format and constants shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
package nl2sc_pkg;

	// command kinds
	localparam logic [1:0] CMD_BYTE  = 2'd0; // one byte
	localparam logic [1:0] CMD_WORD  = 2'd1; // four bytes, msb first
	localparam logic [1:0] CMD_ERROR = 2'd2; // error item, ends the unit

	localparam logic [31:0] START_CODE = 32'h0000_0001;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] word;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic            full;
		logic            not_empty;
		logic [QPTR_W:0] count;
	} q_status_t;

endpackage

// File: src/nl2sc_front.sv
// ----------------------------------------------------------------------------
// nl2sc_front
// Parses incoming bytes of an access unit and issues one output command per
// byte that produces results.
// ----------------------------------------------------------------------------
module nl2sc_front import nl2sc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output cmd_t       cmd
);

	localparam logic [2:0] PH_HEAD    = 3'd0;
	localparam logic [2:0] PH_PASS    = 3'd1;
	localparam logic [2:0] PH_LENGTH  = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_SWALLOW = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [31:0] held_q, held_d;
	logic [31:0] left_q, left_d;
	logic [31:0] shifted;
	logic [31:0] left_dec;
	logic        is_start;

	assign shifted  = {held_q[23:0], in_byte};
	assign left_dec = left_q - 32'd1;
	assign is_start = (shifted[31:24] == 8'h00) && (shifted[23:16] == 8'h00) &&
	                  ((shifted[15:8] == 8'h01) ||
	                   ((shifted[15:8] == 8'h00) && (shifted[7:0] == 8'h01)));

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		held_d   = held_q;
		left_d   = left_q;
		push     = 1'b0;
		cmd.kind = CMD_BYTE;
		cmd.word = {24'd0, in_byte};
		cmd.last = in_last;
		case (phase_q)
			PH_HEAD, PH_LENGTH: begin
				held_d = shifted;
				if (cnt_q != 2'd3) begin
					cnt_d = cnt_q + 2'd1;
					if (in_last) begin
						push     = 1'b1;
						cmd.kind = CMD_ERROR;
					end
				end else if ((phase_q == PH_HEAD) && is_start) begin
					push     = 1'b1;
					cmd.kind = CMD_WORD;
					cmd.word = shifted;
					cnt_d    = 2'd0;
					phase_d  = PH_PASS;
				end else begin
					// complete length field
					cnt_d = 2'd0;
					if (in_last) begin
						push     = 1'b1;
						cmd.kind = CMD_ERROR;
					end else if (shifted == 32'd0) begin
						phase_d = PH_SWALLOW;
					end else begin
						push     = 1'b1;
						cmd.kind = CMD_WORD;
						cmd.word = START_CODE;
						cmd.last = 1'b0;
						left_d   = shifted;
						phase_d  = PH_PAYLOAD;
					end
				end
			end
			PH_PASS: begin
				push = 1'b1;
			end
			PH_PAYLOAD: begin
				left_d = left_dec;
				push   = 1'b1;
				if (left_dec != 32'd0) begin
					if (in_last)
						cmd.kind = CMD_ERROR;
				end else if (!in_last) begin
					phase_d = PH_LENGTH;
					held_d  = 32'd0;
					cnt_d   = 2'd0;
				end
			end
			default: begin
				// swallow until the last byte, then flag the unit
				if (in_last) begin
					push     = 1'b1;
					cmd.kind = CMD_ERROR;
				end
			end
		endcase
		if (cmd.kind == CMD_ERROR) begin
			cmd.word = 32'd0;
			cmd.last = 1'b1;
		end
		// any last byte ends the unit
		if (in_last) begin
			phase_d = PH_HEAD;
			cnt_d   = 2'd0;
			held_d  = 32'd0;
		end
		push = push & fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			cnt_q   <= 2'd0;
			held_q  <= 32'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			held_q  <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			left_q <= left_d;
	end

endmodule

// File: src/nl2sc_queue.sv
// ----------------------------------------------------------------------------
// nl2sc_queue
// Small command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module nl2sc_queue import nl2sc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head_cmd,
	output q_status_t status
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head_cmd         = mem_q[rd_ptr_q];
	assign status.count     = count_q;
	assign status.full      = (count_q == (QPTR_W+1)'(QDEPTH));
	assign status.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/nl2sc_back.sv
// ----------------------------------------------------------------------------
// nl2sc_back
// Expands queued commands into output items, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module nl2sc_back import nl2sc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       unit_error
);

	logic       busy_q;
	cmd_t       cur_q;
	logic [1:0] idx_q;
	logic       take;
	logic       done;
	logic       is_word;

	assign is_word = (cur_q.kind == CMD_WORD);
	assign take    = busy_q & out_ready;
	assign done    = take & (!is_word | (idx_q == 2'd3));
	assign pop     = cmd_valid & (!busy_q | done);

	assign out_valid = busy_q;

	always_comb begin
		out_byte   = cur_q.word[7:0];
		out_last   = cur_q.last;
		unit_error = 1'b0;
		case (cur_q.kind)
			CMD_WORD: begin
				case (idx_q)
					2'd0:    out_byte = cur_q.word[31:24];
					2'd1:    out_byte = cur_q.word[23:16];
					2'd2:    out_byte = cur_q.word[15:8];
					default: out_byte = cur_q.word[7:0];
				endcase
				out_last = cur_q.last & (idx_q == 2'd3);
			end
			CMD_ERROR: begin
				out_byte   = 8'd0;
				out_last   = 1'b1;
				unit_error = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else begin
				if (done)
					busy_q <= 1'b0;
				if (take)
					idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= cmd;
	end

endmodule

// File: src/nal_length_prefix_to_start_code.sv
// Path: an accepted byte's command is written into the command queue, then
// loaded into the back end's current-command register, which drives its items.
// Throughput: one input byte per cycle; each output command drains at one item
// per cycle while out_ready is high, a start code or passed head as four items.
// Input stalls only while the four-entry command queue is full.
// Reset (arst_n, asynchronous, active low): parser returns to head collection,
// queue empties, no output item is pending.
// ----------------------------------------------------------------------------
// nal_length_prefix_to_start_code
// Converts a length-prefixed access unit into start-code form, byte by byte.
// ----------------------------------------------------------------------------
`include "nal_length_prefix_to_start_code_defines.svh"

module nal_length_prefix_to_start_code import nl2sc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       unit_error
);

	logic      fire;
	logic      push;
	logic      pop;
	cmd_t      push_cmd;
	cmd_t      head_cmd;
	q_status_t q_stat;

	assign in_ready = !q_stat.full;
	assign fire     = in_valid & in_ready;

	nl2sc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_byte (in_byte),
		.in_last (in_last),
		.push    (push),
		.cmd     (push_cmd)
	);

	nl2sc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (q_stat)
	);

	nl2sc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_stat.not_empty),
		.cmd        (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.unit_error (unit_error)
	);

	`NL2SC_ASSERT_NOW(a_err_form, clk, arst_n, out_valid && unit_error, out_last && (out_byte == 8'd0))
	`NL2SC_ASSERT_NOW(a_no_overflow, clk, arst_n, push, q_stat.count != (QPTR_W+1)'(QDEPTH))
	`NL2SC_ASSERT_NEXT(a_drain, clk, arst_n, q_stat.not_empty, out_valid)

endmodule

// File: tb/sv/tb_nal_length_prefix_to_start_code.sv
// ----------------------------------------------------------------------------
// tb_nal_length_prefix_to_start_code
// Self-checking bench for the length-prefix to start-code converter. Access
// units (pass-through heads, length-prefixed units, malformed units and noise)
// are fed one byte per item in bursts. The Annex B bytes each one should yield
// are predicted on acceptance and checked in order at the output, which stalls
// in changing patterns.
// ----------------------------------------------------------------------------
module tb_nal_length_prefix_to_start_code;
	timeunit 1ns;
	timeprecision 1ps;

	import nl2sc_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_BYTES = 240;
	localparam int TAIL_CYCLES  = 20;

	typedef enum logic [2:0] {
		HOLD_HEAD, COPY_THROUGH, READ_LENGTH, COPY_PAYLOAD, DISCARD
	} parse_phase_t;

	typedef enum int {
		UNIT_SC4, UNIT_SC3, UNIT_GOOD, UNIT_BROKEN, UNIT_SHORT, UNIT_NOISE
	} unit_kind_t;

	typedef enum int {
		CUT_NONE, CUT_ZERO_LENGTH, CUT_IN_LENGTH, CUT_AT_LENGTH_END, CUT_IN_PAYLOAD
	} unit_cut_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       drain; // wait for all output before driving this item
	} in_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} annexb_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       unit_error;

	in_item_t   unit_bytes_q[$];
	annexb_t    annexb_q[$];

	// converter state as predicted
	parse_phase_t conv_phase;
	logic [31:0]  conv_held;
	logic [1:0]   conv_field_cnt;
	logic [31:0]  conv_left;

	int       bytes_total = 0;
	int       bytes_sent = 0;
	int       units_total = 0;
	int       results_checked = 0;
	int       error_results = 0;
	int       mismatches = 0;
	int       idle_cycles = 0;
	logic     drain_next = 1'b0;

	int       burst_left;
	int       gap_left;
	in_item_t cur;
	int       ready_mode;
	int       mode_left;
	int       toggle_cnt;
	annexb_t  want;

	nal_length_prefix_to_start_code DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.unit_error (unit_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- prediction ----------------

	function automatic void expect_byte(input logic [7:0] d, input logic l, input logic e);
		annexb_t r;
		r.data = d;
		r.last = l;
		r.err  = e;
		annexb_q.insert(annexb_q.size(), r);
	endfunction

	function automatic void restart_unit();
		conv_phase     = HOLD_HEAD;
		conv_held      = '0;
		conv_field_cnt = '0;
		conv_left      = '0;
	endfunction

	function automatic void unit_fault();
		expect_byte(8'h00, 1'b1, 1'b1);
		restart_unit();
	endfunction

	function automatic void length_complete(input logic lst);
		conv_field_cnt = '0;
		if (conv_held == 32'd0) begin
			if (lst)
				unit_fault();
			else
				conv_phase = DISCARD;
		end else if (lst) begin
			unit_fault();
		end else begin
			for (int k = 0; k < 4; k++)
				expect_byte(START_CODE[31 - 8 * k -: 8], 1'b0, 1'b0);
			conv_left  = conv_held;
			conv_phase = COPY_PAYLOAD;
		end
	endfunction

	function automatic void convert_byte(input logic [7:0] b, input logic lst);
		case (conv_phase)
			HOLD_HEAD, READ_LENGTH: begin
				conv_held = {conv_held[23:0], b};
				if (conv_field_cnt != 2'd3) begin
					conv_field_cnt = conv_field_cnt + 2'd1;
					if (lst)
						unit_fault();
				end else if (conv_phase == HOLD_HEAD && conv_held[31:16] == 16'h0000 &&
						(conv_held[15:8] == 8'h01 || conv_held[15:0] == 16'h0001)) begin
					// unit already carries a start code: head goes out as is
					for (int k = 0; k < 4; k++)
						expect_byte(conv_held[31 - 8 * k -: 8], lst && k == 3, 1'b0);
					conv_field_cnt = '0;
					if (lst)
						restart_unit();
					else
						conv_phase = COPY_THROUGH;
				end else begin
					length_complete(lst);
				end
			end
			COPY_THROUGH: begin
				expect_byte(b, lst, 1'b0);
				if (lst)
					restart_unit();
			end
			COPY_PAYLOAD: begin
				conv_left = conv_left - 32'd1;
				if (conv_left != 32'd0) begin
					if (lst)
						unit_fault();
					else
						expect_byte(b, 1'b0, 1'b0);
				end else begin
					expect_byte(b, lst, 1'b0);
					if (lst) begin
						restart_unit();
					end else begin
						conv_phase     = READ_LENGTH;
						conv_held      = '0;
						conv_field_cnt = '0;
					end
				end
			end
			default: begin
				if (lst)
					unit_fault();
			end
		endcase
	endfunction

	// ---------------- stimulus building ----------------

	task automatic add_byte(input logic [7:0] d, input logic l);
		in_item_t it;
		it.data  = d;
		it.last  = l;
		it.drain = drain_next;
		drain_next = 1'b0;
		unit_bytes_q.insert(unit_bytes_q.size(), it);
		bytes_total++;
		if (l)
			units_total++;
	endtask

	// cut = 0 sends the whole field; otherwise only cut bytes, the last one marked
	task automatic add_length(input logic [31:0] len, input int cut);
		int n;
		n = (cut == 0) ? 4 : cut;
		for (int k = 0; k < n; k++)
			add_byte(len[31 - 8 * k -: 8], cut != 0 && k == n - 1);
	endtask

	task automatic add_payload(input int n, input logic ends_unit);
		for (int k = 0; k < n; k++)
			add_byte(8'($urandom_range(0, 255)), ends_unit && k == n - 1);
	endtask

	function automatic logic [31:0] pick_length();
		if ($urandom_range(0, 19) == 0)
			return 32'($urandom_range(20, 48));
		return 32'($urandom_range(1, 8));
	endfunction

	task automatic add_prefixed_unit(input unit_cut_t cut);
		int          nals;
		int          n;
		logic [31:0] len;
		nals = $urandom_range(1, 3);
		for (int i = 0; i < nals; i++) begin
			len = pick_length();
			if (i < nals - 1 || cut == CUT_NONE) begin
				add_length(len, 0);
				add_payload(int'(len), i == nals - 1);
			end else begin
				case (cut)
					CUT_ZERO_LENGTH: begin
						n = $urandom_range(0, 5);
						if (n == 0) begin
							add_length(32'd0, 4);
						end else begin
							add_length(32'd0, 0);
							add_payload(n, 1'b1);
						end
					end
					CUT_IN_LENGTH:     add_length($urandom(), $urandom_range(1, 3));
					CUT_AT_LENGTH_END: add_length($urandom(), 4);
					default: begin
						// unit stops while payload is still owed, sometimes a huge amount
						if ($urandom_range(0, 1) == 0)
							len = $urandom() | 32'h0100_0000;
						else
							len = 32'($urandom_range(2, 10));
						add_length(len, 0);
						add_payload($urandom_range(1, 9 < len - 1 ? 9 : int'(len) - 1), 1'b1);
					end
				endcase
			end
		end
	endtask

	task automatic build_stimulus();
		unit_kind_t kind;
		int         roll;
		int         n;
		int         units_random;
		// directed: short unit, both start-code heads, a clean length, a zero
		// length, and a unit that ends on the last byte of a nonzero length
		add_byte(8'hFF, 1'b1);
		add_length(START_CODE, 4);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h7F, 1'b1);
		add_length(32'd2, 0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b1);
		add_length(32'd0, 0);
		add_byte(8'hAB, 1'b1);
		add_length(32'h8000_0003, 4);

		units_random = 0;
		while (bytes_total < 25 + RANDOM_BYTES) begin
			if (units_random % 9 == 0)
				drain_next = 1'b1;
			units_random++;
			roll = $urandom_range(0, 99);
			if (roll < 18)      kind = UNIT_SC4;
			else if (roll < 28) kind = UNIT_SC3;
			else if (roll < 68) kind = UNIT_GOOD;
			else if (roll < 88) kind = UNIT_BROKEN;
			else if (roll < 93) kind = UNIT_SHORT;
			else                kind = UNIT_NOISE;
			n = $urandom_range(0, 8);
			case (kind)
				UNIT_SC4: begin
					add_length(START_CODE, n == 0 ? 4 : 0);
					add_payload(n, 1'b1);
				end
				UNIT_SC3: begin
					add_byte(8'h00, 1'b0);
					add_byte(8'h00, 1'b0);
					add_byte(8'h01, 1'b0);
					add_byte(8'($urandom_range(0, 255)), n == 0);
					add_payload(n, 1'b1);
				end
				UNIT_GOOD:   add_prefixed_unit(CUT_NONE);
				UNIT_BROKEN: add_prefixed_unit(unit_cut_t'($urandom_range(1, 4)));
				UNIT_SHORT:  add_payload($urandom_range(1, 3), 1'b1);
				default:     add_payload($urandom_range(1, 8), 1'b1);
			endcase
		end
	endtask

	// ---------------- input side ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			in_last <= 1'b0;
			burst_left = 0;
			gap_left = 0;
			restart_unit();
		end else begin
			if (in_valid && in_ready) begin
				convert_byte(in_byte, in_last);
				bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (unit_bytes_q.size() == 0 ||
						(unit_bytes_q[0].drain && annexb_q.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					cur = unit_bytes_q[0];
					unit_bytes_q.delete(0);
					in_valid <= 1'b1;
					in_byte <= cur.data;
					in_last <= cur.last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// ---------------- output side ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_mode = 0;
			mode_left = 0;
			toggle_cnt = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (annexb_q.size() == 0) begin
					$display("%0t: unexpected output item: byte %02h last %0b error %0b",
						$time, out_byte, out_last, unit_error);
					mismatches++;
				end else begin
					want = annexb_q[0];
					annexb_q.delete(0);
					results_checked++;
					if (want.err)
						error_results++;
					if (out_byte !== want.data) begin
						$display("%0t: out_byte expected %02h actual %02h",
							$time, want.data, out_byte);
						mismatches++;
					end
					if (out_last !== want.last) begin
						$display("%0t: out_last expected %0b actual %0b",
							$time, want.last, out_last);
						mismatches++;
					end
					if (unit_error !== want.err) begin
						$display("%0t: unit_error expected %0b actual %0b",
							$time, want.err, unit_error);
						mismatches++;
					end
				end
			end
			// stall pattern: free-running, light random, heavy random, square wave
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(30, 120);
			end
			mode_left--;
			toggle_cnt++;
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ((toggle_cnt / 7) % 2 == 0);
			endcase
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// ---------------- run control ----------------

	initial begin
		build_stimulus();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (bytes_sent != bytes_total || annexb_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Converted %0d access units (%0d bytes in);", units_total, bytes_total);
		$display("checked %0d output bytes, %0d of them error results.",
			results_checked, error_results);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
